/* rtl/core/sle_pkg.sv */
// Shared types and codes for the scancode line editor.
// No dependencies; imported by every module of the block.
package sle_pkg;

  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned KIND_W  = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [KIND_W-1:0] KIND_ECHO_CHAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ECHO_BACK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LINE_CHAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LINE_END  = 2'd3;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_BACK,
    OP_ENTER
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
  } op_t;

endpackage

/* rtl/core/sle_front.sv */
// Front end: accepts scancode words, tracks Shift and Caps Lock, maps to ASCII.
// Emits editor operations into the queue. Depends on sle_pkg.
module sle_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    scancode_i,
  input  logic          q_full_i,
  output logic          push_o,
  output sle_pkg::op_t  push_op_o
);
  import sle_pkg::*;

  localparam logic [6:0] SC_LSHIFT  = 7'h2A;
  localparam logic [6:0] SC_RSHIFT  = 7'h36;
  localparam logic [6:0] SC_CAPS    = 7'h3A;
  localparam int unsigned TABLE_SIZE = 69;
  localparam logic [CHAR_W-1:0] CH_ENTER = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_BACK  = 7'h08;

  localparam logic [CHAR_W-1:0] LOWER_MAP [TABLE_SIZE] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [CHAR_W-1:0] UPPER_MAP [TABLE_SIZE] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  logic              shift_q, shift_d;
  logic              caps_q, caps_d;
  logic              accept;
  logic [6:0]        key;
  logic              is_shift;
  logic [CHAR_W-1:0] ch;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign key        = scancode_i[6:0];
  assign is_shift   = (key == SC_LSHIFT) || (key == SC_RSHIFT);

  always_comb begin
    ch = '0;
    if (key < 7'(TABLE_SIZE)) begin
      ch = (shift_q ^ caps_q) ? UPPER_MAP[key] : LOWER_MAP[key];
    end
  end

  always_comb begin
    shift_d   = shift_q;
    caps_d    = caps_q;
    push_o    = 1'b0;
    push_op_o = '{op: OP_CHAR, ch: ch};
    if (accept) begin
      if (scancode_i[7]) begin
        if (is_shift) shift_d = 1'b0;
      end else if (is_shift) begin
        shift_d = 1'b1;
      end else if (key == SC_CAPS) begin
        caps_d = !caps_q;
      end else if (ch == CH_ENTER) begin
        push_o       = 1'b1;
        push_op_o.op = OP_ENTER;
      end else if (ch == CH_BACK) begin
        push_o       = 1'b1;
        push_op_o.op = OP_BACK;
      end else if (ch != '0) begin
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
    end else begin
      shift_q <= shift_d;
      caps_q  <= caps_d;
    end
  end

endmodule

/* rtl/core/sle_queue.sv */
// Two-entry operation queue between the front end and the line editor.
// Depends on sle_pkg for the operation type.
module sle_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sle_pkg::op_t  push_op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output sle_pkg::op_t  op_o
);
  import sle_pkg::*;

  op_t        ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign op_o    = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_ptr_q] <= push_op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");
`endif

endmodule

/* rtl/core/sle_back.sv */
// Line editor back end: line store memory, fill count, readout sequencer, output register.
// Depends on sle_pkg.
module sle_back #(
  parameter int unsigned LINE_CAPACITY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sle_pkg::LIMIT_W-1:0]   limit_i,
  input  logic                          q_valid_i,
  input  sle_pkg::op_t                  q_op_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sle_pkg::KIND_W-1:0]    kind_o,
  output logic [sle_pkg::CHAR_W-1:0]    character_o,
  output logic [sle_pkg::LEN_W-1:0]     line_length_o,
  output logic                          last_o
);
  import sle_pkg::*;

  localparam int unsigned FILL_W = $clog2(LINE_CAPACITY);
  localparam logic [LIMIT_W-1:0] CAP_LIM = LIMIT_W'(LINE_CAPACITY);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [FILL_W-1:0]  idx_q, idx_d;
  logic [FILL_W-1:0]  rd_addr;
  logic [CHAR_W-1:0]  mem [LINE_CAPACITY];
  logic [CHAR_W-1:0]  rd_data_q;
  logic               wr_en;

  logic               out_valid_q;
  logic [KIND_W-1:0]  kind_q, ld_kind;
  logic [CHAR_W-1:0]  char_q, ld_char;
  logic [LEN_W-1:0]   len_q, ld_len;
  logic               last_q, ld_last;
  logic               load;
  logic               out_free;

  logic [LIMIT_W-1:0] lim_c;
  logic               room;

  always_comb begin
    lim_c = limit_i;
    if (limit_i < LIMIT_W'(2)) lim_c = LIMIT_W'(2);
    else if (limit_i > CAP_LIM) lim_c = CAP_LIM;
  end

  assign room     = (LIMIT_W'(fill_q) + LIMIT_W'(1)) < lim_c;
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && q_valid_i && out_free;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    idx_d   = idx_q;
    rd_addr = idx_q;
    wr_en   = 1'b0;
    load    = 1'b0;
    ld_kind = KIND_ECHO_CHAR;
    ld_char = '0;
    ld_len  = '0;
    ld_last = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        rd_addr = '0;
        if (pop_o) begin
          case (q_op_i.op)
            OP_CHAR: begin
              if (room) begin
                wr_en   = 1'b1;
                fill_d  = fill_q + FILL_W'(1);
                load    = 1'b1;
                ld_kind = KIND_ECHO_CHAR;
                ld_char = q_op_i.ch;
                ld_last = 1'b1;
              end
            end
            OP_BACK: begin
              if (fill_q != '0) begin
                fill_d  = fill_q - FILL_W'(1);
                load    = 1'b1;
                ld_kind = KIND_ECHO_BACK;
                ld_last = 1'b1;
              end
            end
            OP_ENTER: begin
              idx_d   = '0;
              state_d = (fill_q == '0) ? ST_END : ST_DRAIN;
            end
            default: ;
          endcase
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = KIND_LINE_CHAR;
          ld_char = rd_data_q;
          if (idx_q == fill_q - FILL_W'(1)) begin
            state_d = ST_END;
          end else begin
            idx_d   = idx_q + FILL_W'(1);
            rd_addr = idx_q + FILL_W'(1);
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = KIND_LINE_END;
          ld_len  = LEN_W'(fill_q);
          ld_last = 1'b1;
          fill_d  = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[fill_q] <= q_op_i.ch;
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      if (load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= ld_kind;
      char_q <= ld_char;
      len_q  <= ld_len;
      last_q <= ld_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign character_o   = char_q;
  assign line_length_o = len_q;
  assign last_o        = last_q;

`ifndef SYNTH
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> fill_q != '0) else $error("readout of empty line");
  a_drain_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> idx_q < fill_q) else $error("readout index past fill");
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_LINE_END |-> last_q) else $error("line end not last");
`endif

endmodule

/* rtl/core/scancode_line_editor.sv */
// Top level: scancode to ASCII line editor with an APB-style limit register.
// Instantiates sle_front, sle_queue and sle_back; depends on sle_pkg.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | scancode_i
//   out     | output    | out_valid_o / out_stall_i | kind_o, character_o, line_length_o, last_o
//   cfg     | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata (line_limit at 0)
//
// A scancode word is classified in its accept cycle and queued (two entries).
// Echo results are written to the output register as they leave the queue.
// Enter reads the line store at one character per cycle, while the output is not
// stalled, through its registered read port, then emits the line-end word.
// Output stalls back up through the queue to in_stall_o. Reset clears Shift,
// Caps Lock, the fill count and all valids; the line store is not cleared.
module scancode_line_editor #(
  parameter int unsigned LINE_CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  scancode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [6:0]  character_o,
  output logic [5:0]  line_length_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sle_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic               reg_sel;
  logic               push, q_full, pop, q_valid;
  op_t                push_op, q_op;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? 32'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  sle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .scancode_i (scancode_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_op_o  (push_op)
  );

  sle_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .op_o      (q_op)
  );

  sle_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .limit_i       (limit_q),
    .q_valid_i     (q_valid),
    .q_op_i        (q_op),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .character_o   (character_o),
    .line_length_o (line_length_o),
    .last_o        (last_o)
  );

endmodule
